@@ src/zldpl_pkg.sv @@
// Shared constants, register map and helpers for the zoned path loss block.
package zldpl_pkg;

    // Register indexes on the configuration port (paddr[3:2])
    typedef enum logic [1:0] {
        REG_DEFAULT_BASE  = 2'd0,
        REG_DEFAULT_COEFF = 2'd1,
        REG_RAIN_ACTIVE   = 2'd2,
        REG_ZONES_IN_USE  = 2'd3
    } reg_index_t;

    // Input item kinds carried in s_tuser
    localparam logic ACTION_LOAD    = 1'b0;
    localparam logic ACTION_COMPUTE = 1'b1;

    localparam logic [15:0] DEFAULT_BASE_RESET  = 16'd17920;
    localparam logic [15:0] DEFAULT_COEFF_RESET = 16'd6400;

    // Rain adds 10 dB in 1/256 dB and 5.0 in 8.8
    localparam logic [16:0] RAIN_BASE_ADD  = 17'd2560;
    localparam logic [16:0] RAIN_COEFF_ADD = 17'd1280;

    localparam logic [31:0] LOG10_2_Q16 = 32'd19728;
    localparam logic [25:0] ONE_METRE   = 26'd16;

    // Highest power of four at or below the largest 3D squared distance
    localparam logic [49:0] SQRT_BIT_START = 50'd1 << 48;

    // Magnitude of the difference of two 24-bit signed coordinates
    function automatic logic [24:0] abs_diff(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] d;
        d = {a[23], a} - {b[23], b};
        return d[24] ? (25'd0 - d) : d;
    endfunction

endpackage

@@ src/zoned_log_distance_path_loss.sv @@
// Zoned log-distance path loss: zone store, shared multiplier and sequencer.
//
// A load transaction (s_tuser = 0) writes one zone entry and gives an all-zero
// result. Zones are searched in turn. One shared 32x32 multiplier forms every
// square and product in turn, the square root resolves one result bit a cycle,
// normalization shifts one bit a cycle (fewer shifts for longer distances), and
// the log2 fraction is formed one bit at a time over its 16 bits. One
// transaction is in work at a time; s_tready is high only while the sequencer
// is idle. A finished result waits in the final state until the output
// register is free or its result is being taken, then moves into it and the
// block returns to idle.
module zoned_log_distance_path_loss #(
    parameter int MAX_ZONES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // zone_index[3:0], tx_power[19:4], tx_x[43:20], tx_y[67:44], tx_z[91:68],
    // rx_x[115:92], rx_y[139:116], rx_z[163:140], zone_radius[186:164],
    // zone_base_loss[202:187], zone_log_coeff[218:203], zero pad[223:219]
    input  logic [223:0] s_tdata,
    // action[0]
    input  logic         s_tuser,
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // rx_power[23:0], matched_zone[27:24], zero pad[31:28]
    output logic [31:0]  m_tdata,
    // in_zone[0]
    output logic         m_tuser
);
    import zldpl_pkg::*;

    localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW = $clog2(MAX_ZONES + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ZW, ST_ZX, ST_ZY, ST_ZR, ST_ZC,
        ST_D1, ST_D2, ST_D3, ST_D4, ST_SQ, ST_NI, ST_NM,
        ST_LM, ST_LS, ST_K1, ST_K2, ST_K3, ST_K4, ST_DONE
    } state_t;

    // Configuration registers
    logic [15:0] default_base_reg;
    logic [15:0] default_coeff_reg;
    logic        rain_reg;
    logic [4:0]  zones_in_use_reg;

    // Zone store
    logic [23:0] mem_cx    [MAX_ZONES];
    logic [23:0] mem_cy    [MAX_ZONES];
    logic [22:0] mem_rad   [MAX_ZONES];
    logic [15:0] mem_base  [MAX_ZONES];
    logic [15:0] mem_coeff [MAX_ZONES];
    logic [23:0] rd_cx_reg, rd_cy_reg;
    logic [22:0] rd_rad_reg;
    logic [15:0] rd_base_reg, rd_coeff_reg;

    state_t      state_reg;
    logic [15:0] txp_reg;
    logic [23:0] tx_reg, ty_reg, tz_reg, rx_reg, ry_reg, rz_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_lim;
    logic        hit_reg;
    logic [16:0] base_reg, coeff_reg;
    logic [51:0] acc_reg;
    logic [49:0] sq_s_reg, sq_res_reg, sq_bit_reg;
    logic [31:0] m_reg;
    logic [4:0]  p_reg;
    logic [15:0] frac_reg;
    logic [3:0]  cnt_reg;
    logic [19:0] l10_reg;
    logic [63:0] mul_p_reg;
    logic [31:0] mul_a, mul_b;

    logic        m_tvalid_reg;
    logic [23:0] out_power_reg;
    logic [3:0]  out_zone_reg;
    logic        out_hit_reg;
    logic [23:0] res_power_reg;

    // Input field slices
    logic [3:0]  in_zi;
    logic [15:0] in_txp;
    logic [23:0] in_tx, in_ty, in_tz, in_rx, in_ry, in_rz;
    logic [22:0] in_rad;
    logic [15:0] in_base, in_coeff;

    assign in_zi    = s_tdata[3:0];
    assign in_txp   = s_tdata[19:4];
    assign in_tx    = s_tdata[43:20];
    assign in_ty    = s_tdata[67:44];
    assign in_tz    = s_tdata[91:68];
    assign in_rx    = s_tdata[115:92];
    assign in_ry    = s_tdata[139:116];
    assign in_rz    = s_tdata[163:140];
    assign in_rad   = s_tdata[186:164];
    assign in_base  = s_tdata[202:187];
    assign in_coeff = s_tdata[218:203];

    logic s_fire, load_wr, cfg_wr;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign load_wr  = s_fire && (s_tuser == ACTION_LOAD) && (32'(in_zi) < MAX_ZONES);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign n_lim = (32'(zones_in_use_reg) > MAX_ZONES) ? CW'(MAX_ZONES)
                                                       : CW'(zones_in_use_reg);

    // Configuration write and read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_base_reg  <= DEFAULT_BASE_RESET;
            default_coeff_reg <= DEFAULT_COEFF_RESET;
            rain_reg          <= 1'b0;
            zones_in_use_reg  <= 5'd0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_DEFAULT_BASE:  default_base_reg  <= pwdata[15:0];
                REG_DEFAULT_COEFF: default_coeff_reg <= pwdata[15:0];
                REG_RAIN_ACTIVE:   rain_reg          <= pwdata[0];
                REG_ZONES_IN_USE:  zones_in_use_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_DEFAULT_BASE:  prdata = {16'd0, default_base_reg};
            REG_DEFAULT_COEFF: prdata = {16'd0, default_coeff_reg};
            REG_RAIN_ACTIVE:   prdata = {31'd0, rain_reg};
            REG_ZONES_IN_USE:  prdata = {27'd0, zones_in_use_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Zone store: one write port, one registered read port at the scan index
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            mem_cx[AW'(in_zi)]    <= in_tx;
            mem_cy[AW'(in_zi)]    <= in_ty;
            mem_rad[AW'(in_zi)]   <= in_rad;
            mem_base[AW'(in_zi)]  <= in_base;
            mem_coeff[AW'(in_zi)] <= in_coeff;
        end
        rd_cx_reg    <= mem_cx[AW'(idx_reg)];
        rd_cy_reg    <= mem_cy[AW'(idx_reg)];
        rd_rad_reg   <= mem_rad[AW'(idx_reg)];
        rd_base_reg  <= mem_base[AW'(idx_reg)];
        rd_coeff_reg <= mem_coeff[AW'(idx_reg)];
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_ZX:
            begin
                mul_a = 32'(abs_diff(tx_reg, rd_cx_reg));
                mul_b = mul_a;
            end
            ST_ZY:
            begin
                mul_a = 32'(abs_diff(ty_reg, rd_cy_reg));
                mul_b = mul_a;
            end
            ST_ZR:
            begin
                mul_a = 32'(rd_rad_reg);
                mul_b = mul_a;
            end
            ST_D1:
            begin
                mul_a = 32'(abs_diff(tx_reg, rx_reg));
                mul_b = mul_a;
            end
            ST_D2:
            begin
                mul_a = 32'(abs_diff(ty_reg, ry_reg));
                mul_b = mul_a;
            end
            ST_D3:
            begin
                mul_a = 32'(abs_diff(tz_reg, rz_reg));
                mul_b = mul_a;
            end
            ST_LM:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_K1:
            begin
                mul_a = 32'({p_reg - 5'd4, frac_reg});
                mul_b = LOG10_2_Q16;
            end
            ST_K3:
            begin
                mul_a = 32'(coeff_reg);
                mul_b = 32'(l10_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Datapath helpers
    logic [49:0] sq_trial;
    logic        sq_take;
    logic [32:0] sqr_t;
    logic [21:0] loss;
    logic [25:0] diff26;
    logic [25:0] v_init;

    assign sq_trial = sq_res_reg + sq_bit_reg;
    assign sq_take  = (sq_s_reg >= sq_trial);
    assign sqr_t    = mul_p_reg[63:31];
    assign loss     = 22'(base_reg) + mul_p_reg[36:16];
    assign diff26   = {{10{txp_reg[15]}}, txp_reg} - {4'd0, loss};
    assign v_init   = sq_res_reg[25:0] + ONE_METRE;

    // Sequencer, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_power_reg <= 24'd0;
            out_zone_reg  <= 4'd0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            // Drop a taken result unless the final state refills it this cycle
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        txp_reg <= in_txp;
                        tx_reg  <= in_tx;
                        ty_reg  <= in_ty;
                        tz_reg  <= in_tz;
                        rx_reg  <= in_rx;
                        ry_reg  <= in_ry;
                        rz_reg  <= in_rz;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        res_power_reg <= 24'd0;
                        if (s_tuser == ACTION_LOAD)
                            state_reg <= ST_DONE;
                        else if (n_lim == '0)
                        begin
                            base_reg  <= {1'b0, default_base_reg};
                            coeff_reg <= {1'b0, default_coeff_reg};
                            state_reg <= ST_D1;
                        end
                        else
                            state_reg <= ST_ZW;
                    end
                end
                ST_ZW: state_reg <= ST_ZX;
                ST_ZX: state_reg <= ST_ZY;
                ST_ZY:
                begin
                    acc_reg   <= mul_p_reg[51:0];
                    state_reg <= ST_ZR;
                end
                ST_ZR:
                begin
                    acc_reg   <= acc_reg + mul_p_reg[51:0];
                    state_reg <= ST_ZC;
                end
                ST_ZC:
                begin
                    if (acc_reg <= mul_p_reg[51:0])
                    begin
                        hit_reg   <= 1'b1;
                        base_reg  <= {1'b0, rd_base_reg} + (rain_reg ? RAIN_BASE_ADD : 17'd0);
                        coeff_reg <= {1'b0, rd_coeff_reg} + (rain_reg ? RAIN_COEFF_ADD : 17'd0);
                        state_reg <= ST_D1;
                    end
                    else if (idx_reg + 1'b1 == n_lim)
                    begin
                        base_reg  <= {1'b0, default_base_reg};
                        coeff_reg <= {1'b0, default_coeff_reg};
                        state_reg <= ST_D1;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_ZW;
                    end
                end
                ST_D1: state_reg <= ST_D2;
                ST_D2:
                begin
                    acc_reg   <= mul_p_reg[51:0];
                    state_reg <= ST_D3;
                end
                ST_D3:
                begin
                    acc_reg   <= acc_reg + mul_p_reg[51:0];
                    state_reg <= ST_D4;
                end
                ST_D4:
                begin
                    sq_s_reg   <= 50'(acc_reg + mul_p_reg[51:0]);
                    sq_res_reg <= 50'd0;
                    sq_bit_reg <= SQRT_BIT_START;
                    state_reg  <= ST_SQ;
                end
                ST_SQ:
                begin
                    // One result bit of the integer square root per cycle
                    if (sq_take)
                    begin
                        sq_s_reg   <= sq_s_reg - sq_trial;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == 50'd1)
                        state_reg <= ST_NI;
                end
                ST_NI:
                begin
                    m_reg     <= {v_init, 6'd0};
                    p_reg     <= 5'd25;
                    state_reg <= ST_NM;
                end
                ST_NM:
                begin
                    // Shift until the top bit is set
                    if (m_reg[31])
                    begin
                        cnt_reg   <= 4'd0;
                        frac_reg  <= 16'd0;
                        state_reg <= ST_LM;
                    end
                    else
                    begin
                        m_reg <= m_reg << 1;
                        p_reg <= p_reg - 5'd1;
                    end
                end
                ST_LM: state_reg <= ST_LS;
                ST_LS:
                begin
                    frac_reg <= {frac_reg[14:0], sqr_t[32]};
                    m_reg    <= sqr_t[32] ? sqr_t[32:1] : sqr_t[31:0];
                    cnt_reg  <= cnt_reg + 4'd1;
                    state_reg <= (cnt_reg == 4'd15) ? ST_K1 : ST_LM;
                end
                ST_K1: state_reg <= ST_K2;
                ST_K2:
                begin
                    l10_reg   <= mul_p_reg[35:16];
                    state_reg <= ST_K3;
                end
                ST_K3: state_reg <= ST_K4;
                ST_K4:
                begin
                    if (diff26[25] && (diff26[24:23] != 2'b11))
                        res_power_reg <= 24'h800000;
                    else if (!diff26[25] && (diff26[24:23] != 2'b00))
                        res_power_reg <= 24'h7FFFFF;
                    else
                        res_power_reg <= diff26[23:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        out_power_reg <= res_power_reg;
                        out_hit_reg   <= hit_reg;
                        out_zone_reg  <= hit_reg ? 4'(idx_reg) : 4'd0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_zone_reg, out_power_reg};
    assign m_tuser  = out_hit_reg;

    // No match means matched_zone reads zero
    a_zone_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[27:24] == 4'd0))
        else $error("matched_zone nonzero without a zone match");

    // Scan index stays within the searched range
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZC) |-> (idx_reg < n_lim))
        else $error("zone scan index out of range");

    // Normalization never moves the top bit below one metre
    a_norm_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NM) |-> (p_reg >= 5'd4))
        else $error("log normalization ran past one metre");

    // A new result is loaded only from the final state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented outside the final state");

endmodule

@@ tb/zoned_log_distance_path_loss_tb.sv @@
// Self-checking testbench for the zoned log-distance path loss block.
module zoned_log_distance_path_loss_tb;
    import zldpl_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic        action;
        logic [3:0]  zone_index;
        logic [15:0] tx_power;
        logic [23:0] tx_x, tx_y, tx_z, rx_x, rx_y, rx_z;
        logic [22:0] zone_radius;
        logic [15:0] zone_base_loss, zone_log_coeff;
    } link_item_t;

    typedef struct packed {
        logic [23:0] rx_power;
        logic        in_zone;
        logic [3:0]  matched_zone;
    } power_result_t;

    logic         clk;
    logic         rst_n;
    logic         psel, penable, pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid, s_tready;
    logic [223:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid, m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    zoned_log_distance_path_loss u_dut (.*);

    // predictor state
    logic [23:0] zc_x [16];
    logic [23:0] zc_y [16];
    logic [22:0] z_rad [16];
    logic [15:0] z_base [16];
    logic [15:0] z_coeff [16];
    logic [15:0] dflt_base, dflt_coeff;
    logic        rain_on;
    logic [4:0]  zone_count;

    link_item_t    pending_items[$];
    power_result_t expected_powers[$];

    int  send_idle_pct, recv_idle_pct;
    bit  hold_request;
    bit  hold_off;
    int  error_count = 0;
    longint cycle_count = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint sdiff_sq(logic [23:0] a, logic [23:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return d * d;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned log10_of_dist(longint unsigned d);
        longint unsigned v, m, frac, l2;
        int p;
        v = d + 16;
        p = 0;
        while ((v >> (p + 1)) != 0) p++;
        m = (p <= 31) ? (v << (31 - p)) : (v >> (p - 31));
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac <<= 1;
            if (m >= (64'd1 << 32)) begin
                frac |= 1;
                m >>= 1;
            end
        end
        l2 = (longint'(p - 4) << 16) | frac;
        return (l2 * 19728) >> 16;
    endfunction

    function automatic power_result_t predict_power(link_item_t it);
        power_result_t res;
        longint unsigned base, coeff, loss, d, rad;
        longint r;
        int n;
        bit hit;
        res = '0;
        if (it.action == ACTION_LOAD) begin
            zc_x[it.zone_index] = it.tx_x;
            zc_y[it.zone_index] = it.tx_y;
            z_rad[it.zone_index] = it.zone_radius;
            z_base[it.zone_index] = it.zone_base_loss;
            z_coeff[it.zone_index] = it.zone_log_coeff;
            return res;
        end
        n = (zone_count > 16) ? 16 : zone_count;
        hit = 0;
        for (int k = 0; k < n && !hit; k++) begin
            rad = u64_t'(z_rad[k]);
            if (u64_t'(sdiff_sq(it.tx_x, zc_x[k]) + sdiff_sq(it.tx_y, zc_y[k]))
                    <= rad * rad) begin
                hit = 1;
                res.matched_zone = k[3:0];
            end
        end
        if (hit) begin
            base = z_base[res.matched_zone];
            coeff = z_coeff[res.matched_zone];
            if (rain_on) begin
                base += 2560;
                coeff += 1280;
            end
        end
        else begin
            base = dflt_base;
            coeff = dflt_coeff;
        end
        d = int_sqrt(u64_t'(sdiff_sq(it.tx_x, it.rx_x) + sdiff_sq(it.tx_y, it.rx_y)
                     + sdiff_sq(it.tx_z, it.rx_z)));
        loss = base + ((coeff * log10_of_dist(d)) >> 16);
        r = longint'($signed(it.tx_power)) - longint'(loss);
        if (r < -8388608) r = -8388608;
        if (r > 8388607) r = 8388607;
        res.rx_power = r[23:0];
        res.in_zone = hit;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic reg_write(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_DEFAULT_BASE:  dflt_base = value[15:0];
            REG_DEFAULT_COEFF: dflt_coeff = value[15:0];
            REG_RAIN_ACTIVE:   rain_on = value[0];
            default:           zone_count = value[4:0];
        endcase
    endtask

    // Wait until the queues drain, then let the block settle.
    task automatic drain();
        while (pending_items.size() != 0 || expected_powers.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic link_item_t rand_coords(link_item_t it, int span);
        it.tx_x = 24'($urandom_range(0, 2 * span) - span);
        it.tx_y = 24'($urandom_range(0, 2 * span) - span);
        it.tx_z = 24'($urandom_range(0, 2 * span) - span);
        it.rx_x = 24'($urandom_range(0, 2 * span) - span);
        it.rx_y = 24'($urandom_range(0, 2 * span) - span);
        it.rx_z = 24'($urandom_range(0, 2 * span) - span);
        return it;
    endfunction

    function automatic link_item_t rand_item();
        link_item_t it;
        int sel;
        it = '0;
        it.tx_power = 16'($urandom);
        it.zone_index = 4'($urandom);
        it.zone_radius = 23'($urandom);
        it.zone_base_loss = 16'($urandom);
        it.zone_log_coeff = 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 5) it = rand_coords(it, 4000);
        else if (sel < 8) it = rand_coords(it, 400000);
        else begin
            it.tx_x = 24'($urandom); it.tx_y = 24'($urandom); it.tx_z = 24'($urandom);
            it.rx_x = 24'($urandom); it.rx_y = 24'($urandom); it.rx_z = 24'($urandom);
        end
        if (sel < 7) it.zone_radius = 23'($urandom_range(0, 6000));
        it.action = ($urandom_range(0, 4) != 0) ? ACTION_COMPUTE : ACTION_LOAD;
        return it;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                link_item_t it;
                it = pending_items.pop_front();
                expected_powers = {expected_powers, predict_power(it)};
                s_tvalid <= 1'b1;
                s_tuser <= it.action;
                s_tdata <= {5'd0, it.zone_log_coeff, it.zone_base_loss, it.zone_radius,
                            it.rx_z, it.rx_y, it.rx_x, it.tx_z, it.tx_y, it.tx_x,
                            it.tx_power, it.zone_index};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, counted in its own process
    initial begin
        hold_off <= 1'b0;
        wait (hold_request);
        hold_off <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result monitor and ready control
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_powers.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 32'd0);
                else begin
                    power_result_t want;
                    want = expected_powers.pop_front();
                    if (m_tdata[23:0] !== want.rx_power)
                        report_mismatch("rx_power", 32'(m_tdata[23:0]), 32'(want.rx_power));
                    if (m_tuser !== want.in_zone)
                        report_mismatch("in_zone", 32'(m_tuser), 32'(want.in_zone));
                    if (m_tdata[27:24] !== want.matched_zone)
                        report_mismatch("matched_zone", 32'(m_tdata[27:24]),
                                        32'(want.matched_zone));
                    if (m_tdata[31:28] !== 4'd0)
                        report_mismatch("pad", 32'(m_tdata[31:28]), 32'd0);
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("zoned_log_distance_path_loss_tb NOT OK");
            $finish;
        end
    end

    initial begin
        link_item_t it;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        send_idle_pct = 0; recv_idle_pct = 0; hold_request = 0;
        dflt_base = DEFAULT_BASE_RESET; dflt_coeff = DEFAULT_COEFF_RESET;
        rain_on = 0; zone_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: defaults only, extremes of distance and power
        it = '0; it.action = ACTION_COMPUTE;
        pending_items = {pending_items, it};
        it.tx_power = 16'h7FFF; it.tx_x = 24'h7FFFFF; it.tx_y = 24'h7FFFFF;
        it.tx_z = 24'h7FFFFF; it.rx_x = 24'h800000; it.rx_y = 24'h800000;
        it.rx_z = 24'h800000;
        pending_items = {pending_items, it};
        it.tx_power = 16'h8000;
        pending_items = {pending_items, it};
        drain();
        reg_write(REG_DEFAULT_BASE, 32'hFFFF);
        reg_write(REG_DEFAULT_COEFF, 32'hFFFF);
        pending_items = {pending_items, it};
        it = '0; it.action = ACTION_COMPUTE; it.tx_power = 16'h8000; it.rx_z = 24'd1;
        pending_items = {pending_items, it};
        drain();
        reg_write(REG_DEFAULT_BASE, 32'h0);
        reg_write(REG_DEFAULT_COEFF, 32'h0);

        // load all zones, including extreme contents
        for (int k = 0; k < 16; k++) begin
            it = rand_item();
            it.action = ACTION_LOAD;
            it.zone_index = k[3:0];
            if (k == 0) begin
                it.tx_x = 24'h800000; it.tx_y = 24'h7FFFFF;
                it.zone_radius = 23'h7FFFFF; it.zone_base_loss = 16'hFFFF;
                it.zone_log_coeff = 16'hFFFF;
            end
            if (k == 1) begin
                it.zone_radius = '0; it.zone_base_loss = '0; it.zone_log_coeff = '0;
            end
            pending_items = {pending_items, it};
        end
        drain();
        reg_write(REG_ZONES_IN_USE, 32'd31);
        reg_write(REG_RAIN_ACTIVE, 32'd1);
        it = rand_item(); it.action = ACTION_COMPUTE;
        pending_items = {pending_items, it};
        it.tx_x = 24'h800000; it.tx_y = 24'h7FFFFF; it.tx_power = 16'h7FFF;
        pending_items = {pending_items, it};
        drain();
        reg_write(REG_RAIN_ACTIVE, 32'd0);
        reg_write(REG_ZONES_IN_USE, 32'd16);
        pending_items = {pending_items, it};
        drain();

        // random phases with different settings and idling
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph % 3 == 0) ? 35 : (ph % 3 == 1) ? 66 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 66 : (ph % 3 == 1) ? 35 : 0;
            reg_write(REG_DEFAULT_BASE, $urandom_range(0, 65535));
            reg_write(REG_DEFAULT_COEFF, $urandom_range(0, 65535));
            reg_write(REG_RAIN_ACTIVE, ph % 2);
            reg_write(REG_ZONES_IN_USE, (ph == 5) ? 0 : $urandom_range(1, 16));
            for (int i = 0; i < 290; i++) begin
                pending_items = {pending_items, rand_item()};
                if (ph == 1 && i == 40)
                    hold_request = 1;
            end
            // sender pauses until all results are back
            drain();
        end

        if (error_count == 0)
            $display("zoned_log_distance_path_loss_tb OK");
        else
            $display("zoned_log_distance_path_loss_tb NOT OK");
        $finish;
    end
endmodule

@@ sim.f @@
src/zldpl_pkg.sv
src/zoned_log_distance_path_loss.sv
tb/zoned_log_distance_path_loss_tb.sv
